// File: rtl/core/adaptive_local_noise_filter_defines.svh
// Assertion macros for the adaptive local noise filter.
// No dependencies; included by files that carry concurrent checks.
`ifndef ADAPTIVE_LOCAL_NOISE_FILTER_DEFINES_SVH
`define ADAPTIVE_LOCAL_NOISE_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define ALNF_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ALNF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/alnf_pkg.sv
// Shared types and constants of the adaptive local noise filter.
// No dependencies; used by the interfaces, the filter and the testbench.
package alnf_pkg;

   localparam int CHAN_W    = 8;
   localparam int CHANNELS  = 3;
   localparam int PIXEL_W   = CHAN_W * CHANNELS;
   localparam int COLUMN_W  = 10;
   localparam int ROW_W     = 16;
   localparam int LWIDTH_W  = 11;
   localparam int NOISE_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_VARIANCE = 2'd1;

   localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RST = 11'd640;
   localparam logic [NOISE_W-1:0]  NOISE_RST      = 16'd1000;
   localparam logic [ROW_W-1:0]    ROW_MAX        = 16'hFFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ACC,
      ST_SQR,
      ST_DIFF,
      ST_PROD,
      ST_SUB,
      ST_DIV,
      ST_ROUND,
      ST_EMIT
   } alnf_state_type;

endpackage

// File: rtl/core/alnf_req_if.sv
// Pixel input channel: valid/ready plus one RGB word.
// Depends on alnf_pkg.
interface alnf_req_if;
   logic                          valid;
   logic                          ready;
   logic [alnf_pkg::CHAN_W-1:0]   pixel_red;
   logic [alnf_pkg::CHAN_W-1:0]   pixel_green;
   logic [alnf_pkg::CHAN_W-1:0]   pixel_blue;
   logic                          start_of_frame;

   modport source (output valid, pixel_red, pixel_green, pixel_blue, start_of_frame,
                   input ready);
   modport sink   (input valid, pixel_red, pixel_green, pixel_blue, start_of_frame,
                   output ready);
endinterface

// File: rtl/core/alnf_rsp_if.sv
// Filtered result channel: valid/ready plus centre values and position.
// Depends on alnf_pkg.
interface alnf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [alnf_pkg::CHAN_W-1:0]     out_red;
   logic [alnf_pkg::CHAN_W-1:0]     out_green;
   logic [alnf_pkg::CHAN_W-1:0]     out_blue;
   logic [alnf_pkg::COLUMN_W-1:0]   out_column;
   logic [alnf_pkg::ROW_W-1:0]      out_row;

   modport source (output valid, out_red, out_green, out_blue, out_column, out_row,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_column, out_row,
                   output ready);
endinterface

// File: rtl/core/alnf_csr_if.sv
// Register write channel: valid/ready, register index and data.
// Depends on alnf_pkg.
interface alnf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [alnf_pkg::CSR_IDX_W-1:0]   index;
   logic [alnf_pkg::CSR_DAT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/adaptive_local_noise_filter.sv
// Adaptive local noise filter over a WINDOW x WINDOW neighborhood of an RGB raster
// stream. One pixel is taken at a time: a pixel whose window is not complete (image
// border) goes through accept, then line store read-modify-write, and no more. A pixel
// that yields a result then sums the window column by column, then per color channel
// runs multiply, compare and, unless the result is clipped to zero, a 10-step restoring
// division with half-even rounding; the last step waits as long as an earlier result
// is still held in the output register. The line store is one RAM word per column; a
// finished result waits in an output register while the next pixel is taken. Depends
// on alnf_pkg, the channel interfaces, alnf_line_mem and the assertion macro header.
`include "adaptive_local_noise_filter_defines.svh"

module adaptive_local_noise_filter #(
   parameter int WINDOW    = 7,
   parameter int MAX_WIDTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   alnf_req_if.sink   req_ch,
   alnf_rsp_if.source rsp_ch,
   alnf_csr_if.sink   csr_ch
);

   localparam int HALF  = (WINDOW - 1) / 2;
   localparam int LINES = WINDOW - 1;
   localparam int AREA  = WINDOW * WINDOW;
   localparam int PXW   = alnf_pkg::PIXEL_W;
   localparam int CHW   = alnf_pkg::CHAN_W;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = (CW + 1 > alnf_pkg::LWIDTH_W) ? CW + 1 : alnf_pkg::LWIDTH_W;
   localparam int SW    = $clog2(AREA * 255 + 1);
   localparam int QW    = $clog2(AREA * 65025 + 1);
   localparam int DW    = QW + $clog2(AREA + 1);
   localparam int TW    = alnf_pkg::NOISE_W + $clog2(AREA * AREA + 1);
   localparam int NMW   = alnf_pkg::NOISE_W + $clog2(AREA);
   localparam int GW    = SW + 1;
   localparam int PW3   = NMW + GW + 1;
   localparam int NUMW  = ((CHW + DW > PW3) ? CHW + DW : PW3) + 1;
   localparam int QB    = 10;
   localparam int RW    = NUMW + QB;
   localparam int XW    = (TW > DW) ? TW : DW;
   localparam int QCW   = $clog2(QB);
   localparam int WCW   = $clog2(WINDOW);
   localparam int MW    = LINES * PXW;

   alnf_pkg::alnf_state_type state_ff, state_in;

   logic [CW-1:0]                 col_ff;
   logic [alnf_pkg::ROW_W-1:0]    row_ff;
   logic [CW-1:0]                 cc_ff;
   logic [alnf_pkg::ROW_W-1:0]    rc_ff;
   logic [PXW-1:0]                px_ff;
   logic                          emit_ff;
   logic [alnf_pkg::LWIDTH_W-1:0] lw_ff;
   logic [alnf_pkg::NOISE_W-1:0]  nv_ff;

   logic [PXW-1:0] win_ff [WINDOW][WINDOW];
   logic [PXW-1:0] win_in [WINDOW][WINDOW];

   logic [SW-1:0]  s_ff  [alnf_pkg::CHANNELS];
   logic [QW-1:0]  q_ff  [alnf_pkg::CHANNELS];
   logic [CHW-1:0] res_ff [alnf_pkg::CHANNELS];
   logic [SW-1:0]  cs_w  [alnf_pkg::CHANNELS];
   logic [QW-1:0]  cq_w  [alnf_pkg::CHANNELS];

   logic [WCW-1:0]           cnt_ff;
   logic [1:0]               ch_ff;
   logic [QCW-1:0]           bit_ff;
   logic [TW-1:0]            thr_ff;
   logic [NMW-1:0]           nvm_ff;
   logic [DW-1:0]            nq_ff, ss_ff, d_ff, den_ff;
   logic [CHW-1:0]           g_ff;
   logic signed [GW-1:0]     ngs_ff;
   logic [CHW+DW-1:0]        gd_ff;
   logic signed [PW3-1:0]    t3_ff;
   logic [RW-1:0]            rem_ff, dsh_ff;
   logic [QB-1:0]            quo_ff;
   logic                     ovf_ff;

   logic                     rsp_valid_ff;
   logic [CHW-1:0]           out_red_ff, out_green_ff, out_blue_ff;
   logic [alnf_pkg::COLUMN_W-1:0] out_col_ff;
   logic [alnf_pkg::ROW_W-1:0]    out_row_ff;

   // accept-side signals
   logic                       acc_w;
   logic [CW-1:0]              c_w;
   logic [alnf_pkg::ROW_W-1:0] r_w;
   logic [WW-1:0]              width_w;
   logic [CW:0]                cnext_w;
   logic                       wrap_w;
   logic                       emit_w;
   logic [MW-1:0]              rd_data_w, wr_data_w;

   // per-channel working values
   logic [SW-1:0]            s_sel;
   logic [QW-1:0]            q_sel;
   logic [CHW-1:0]           g_sel;
   logic                     mean_w;
   logic signed [NUMW-1:0]   num_w;
   logic                     num_pos_w;
   logic                     ge_w;
   logic [RW:0]              twor_w;
   logic                     up_w;
   logic [QB:0]              qr_w;
   logic [CHW-1:0]           sat_w;
   logic                     last_ch_w;
   logic                     out_free_w;
   logic                     out_load_w;

   assign req_ch.ready = (state_ff == alnf_pkg::ST_IDLE);
   assign acc_w        = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign c_w     = req_ch.start_of_frame ? '0 : col_ff;
   assign r_w     = req_ch.start_of_frame ? '0 : row_ff;
   assign cnext_w = (CW + 1)'(c_w) + (CW + 1)'(1);
   assign wrap_w  = WW'(cnext_w) >= width_w;
   assign emit_w  = (r_w >= alnf_pkg::ROW_W'(WINDOW - 1)) && (c_w >= CW'(WINDOW - 1));

   always_comb begin
      if (lw_ff == '0) begin
         width_w = WW'(1);
      end else if (WW'(lw_ff) > WW'(MAX_WIDTH)) begin
         width_w = WW'(MAX_WIDTH);
      end else begin
         width_w = WW'(lw_ff);
      end
   end

   // line store column word: shift up one row, newest pixel on top
   always_comb begin
      for (int k = 0; k < LINES - 1; k++) begin
         wr_data_w[k*PXW +: PXW] = rd_data_w[(k+1)*PXW +: PXW];
      end
      wr_data_w[(LINES-1)*PXW +: PXW] = px_ff;
   end

   alnf_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (MW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (state_ff == alnf_pkg::ST_LOAD),
      .wr_addr (cc_ff),
      .wr_data (wr_data_w),
      .rd_en   (acc_w),
      .rd_addr (c_w),
      .rd_data (rd_data_w)
   );

   // window: shift in a new column on load, rotate one column per summing cycle
   always_comb begin
      win_in = win_ff;
      if (state_ff == alnf_pkg::ST_LOAD) begin
         for (int k = 0; k < WINDOW; k++) begin
            for (int j = 0; j < WINDOW - 1; j++) begin
               win_in[k][j] = win_ff[k][j+1];
            end
            win_in[k][WINDOW-1] = (k < LINES) ? rd_data_w[k*PXW +: PXW] : px_ff;
         end
      end else if (state_ff == alnf_pkg::ST_ACC) begin
         for (int k = 0; k < WINDOW; k++) begin
            for (int j = 0; j < WINDOW - 1; j++) begin
               win_in[k][j] = win_ff[k][j+1];
            end
            win_in[k][WINDOW-1] = win_ff[k][0];
         end
      end
   end

   // column 0 sums and sums of squares, all channels
   always_comb begin
      for (int ch = 0; ch < alnf_pkg::CHANNELS; ch++) begin
         cs_w[ch] = '0;
         cq_w[ch] = '0;
         for (int k = 0; k < WINDOW; k++) begin
            cs_w[ch] = cs_w[ch] + SW'(win_ff[k][0][ch*CHW +: CHW]);
            cq_w[ch] = cq_w[ch] + QW'(16'(win_ff[k][0][ch*CHW +: CHW])
                                    * 16'(win_ff[k][0][ch*CHW +: CHW]));
         end
      end
   end

   assign s_sel     = s_ff[ch_ff];
   assign q_sel     = q_ff[ch_ff];
   assign g_sel     = win_ff[HALF][HALF][ch_ff*CHW +: CHW];
   assign mean_w    = (d_ff == '0) || (XW'(thr_ff) > XW'(d_ff));
   assign num_w     = $signed(NUMW'(gd_ff)) - NUMW'(t3_ff);
   assign num_pos_w = !num_w[NUMW-1] && (num_w != '0);
   assign ge_w      = rem_ff >= dsh_ff;
   assign twor_w    = {rem_ff, 1'b0};
   assign up_w      = (twor_w > (RW + 1)'(den_ff))
                   || ((twor_w == (RW + 1)'(den_ff)) && quo_ff[0]);
   assign qr_w      = (QB + 1)'(quo_ff) + (QB + 1)'(up_w);
   assign sat_w     = (ovf_ff || (qr_w > (QB + 1)'(255))) ? 8'hFF : qr_w[CHW-1:0];
   assign last_ch_w = (ch_ff == 2'(alnf_pkg::CHANNELS - 1));

   assign out_free_w = !rsp_valid_ff || rsp_ch.ready;
   assign out_load_w = (state_ff == alnf_pkg::ST_EMIT) && out_free_w;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         alnf_pkg::ST_IDLE:  if (acc_w) state_in = alnf_pkg::ST_LOAD;
         alnf_pkg::ST_LOAD:  state_in = emit_ff ? alnf_pkg::ST_ACC : alnf_pkg::ST_IDLE;
         alnf_pkg::ST_ACC: begin
            if (cnt_ff == WCW'(WINDOW - 1)) state_in = alnf_pkg::ST_SQR;
         end
         alnf_pkg::ST_SQR:   state_in = alnf_pkg::ST_DIFF;
         alnf_pkg::ST_DIFF:  state_in = alnf_pkg::ST_PROD;
         alnf_pkg::ST_PROD:  state_in = mean_w ? alnf_pkg::ST_DIV : alnf_pkg::ST_SUB;
         alnf_pkg::ST_SUB: begin
            if (num_pos_w) begin
               state_in = alnf_pkg::ST_DIV;
            end else begin
               state_in = last_ch_w ? alnf_pkg::ST_EMIT : alnf_pkg::ST_SQR;
            end
         end
         alnf_pkg::ST_DIV: begin
            if (bit_ff == '0) state_in = alnf_pkg::ST_ROUND;
         end
         alnf_pkg::ST_ROUND: state_in = last_ch_w ? alnf_pkg::ST_EMIT : alnf_pkg::ST_SQR;
         alnf_pkg::ST_EMIT:  if (out_free_w) state_in = alnf_pkg::ST_IDLE;
         default:            state_in = alnf_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alnf_pkg::ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         emit_ff      <= 1'b0;
         lw_ff        <= alnf_pkg::LINE_WIDTH_RST;
         nv_ff        <= alnf_pkg::NOISE_RST;
         cnt_ff       <= '0;
         ch_ff        <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (acc_w) begin
            emit_ff <= emit_w;
            if (wrap_w) begin
               col_ff <= '0;
               row_ff <= (r_w != alnf_pkg::ROW_MAX) ? r_w + 16'd1 : r_w;
            end else begin
               col_ff <= cnext_w[CW-1:0];
               row_ff <= r_w;
            end
         end
         // writes to unused register indexes are ignored
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               alnf_pkg::CSR_LINE_WIDTH:     lw_ff <= csr_ch.data[alnf_pkg::LWIDTH_W-1:0];
               alnf_pkg::CSR_NOISE_VARIANCE: nv_ff <= csr_ch.data;
               default: ;
            endcase
         end
         unique case (state_ff)
            alnf_pkg::ST_LOAD: begin
               cnt_ff <= '0;
               ch_ff  <= '0;
            end
            alnf_pkg::ST_ACC:  cnt_ff <= cnt_ff + WCW'(1);
            alnf_pkg::ST_PROD: if (mean_w) bit_ff <= QCW'(QB - 1);
            alnf_pkg::ST_SUB: begin
               bit_ff <= QCW'(QB - 1);
               if (!num_pos_w) ch_ff <= ch_ff + 2'd1;
            end
            alnf_pkg::ST_DIV:   bit_ff <= bit_ff - QCW'(1);
            alnf_pkg::ST_ROUND: ch_ff <= ch_ff + 2'd1;
            default: ;
         endcase
         if (out_load_w) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (acc_w) begin
         px_ff <= {req_ch.pixel_blue, req_ch.pixel_green, req_ch.pixel_red};
         cc_ff <= c_w;
         rc_ff <= r_w;
      end
      unique case (state_ff)
         alnf_pkg::ST_LOAD: begin
            for (int ch = 0; ch < alnf_pkg::CHANNELS; ch++) begin
               s_ff[ch] <= '0;
               q_ff[ch] <= '0;
            end
            thr_ff <= TW'(nv_ff) * TW'(AREA * (AREA - 1));
            nvm_ff <= NMW'(nv_ff) * NMW'(AREA - 1);
         end
         alnf_pkg::ST_ACC: begin
            for (int ch = 0; ch < alnf_pkg::CHANNELS; ch++) begin
               s_ff[ch] <= s_ff[ch] + cs_w[ch];
               q_ff[ch] <= q_ff[ch] + cq_w[ch];
            end
         end
         alnf_pkg::ST_SQR: begin
            nq_ff  <= DW'(q_sel) * DW'(AREA);
            ss_ff  <= DW'(s_sel) * DW'(s_sel);
            g_ff   <= g_sel;
            ngs_ff <= $signed(GW'(SW'(AREA) * SW'(g_sel))) - $signed(GW'(s_sel));
         end
         alnf_pkg::ST_DIFF: d_ff <= nq_ff - ss_ff;
         alnf_pkg::ST_PROD: begin
            if (mean_w) begin
               rem_ff <= RW'(s_sel);
               den_ff <= DW'(AREA);
               dsh_ff <= RW'(AREA) << (QB - 1);
               ovf_ff <= 1'b0;
               quo_ff <= '0;
            end else begin
               gd_ff  <= g_ff * d_ff;
               t3_ff  <= $signed({1'b0, nvm_ff}) * ngs_ff;
               den_ff <= d_ff;
            end
         end
         alnf_pkg::ST_SUB: begin
            rem_ff <= RW'($unsigned(num_w));
            dsh_ff <= RW'(den_ff) << (QB - 1);
            ovf_ff <= RW'($unsigned(num_w)) >= (RW'(den_ff) << QB);
            quo_ff <= '0;
            if (!num_pos_w) res_ff[ch_ff] <= '0;
         end
         alnf_pkg::ST_DIV: begin
            if (ge_w) rem_ff <= rem_ff - dsh_ff;
            quo_ff <= {quo_ff[QB-2:0], ge_w};
            dsh_ff <= dsh_ff >> 1;
         end
         alnf_pkg::ST_ROUND: res_ff[ch_ff] <= sat_w;
         default: ;
      endcase
      if (out_load_w) begin
         out_red_ff   <= res_ff[0];
         out_green_ff <= res_ff[1];
         out_blue_ff  <= res_ff[2];
         out_col_ff   <= alnf_pkg::COLUMN_W'(cc_ff - CW'(HALF));
         out_row_ff   <= rc_ff - alnf_pkg::ROW_W'(HALF);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_red    = out_red_ff;
   assign rsp_ch.out_green  = out_green_ff;
   assign rsp_ch.out_blue   = out_blue_ff;
   assign rsp_ch.out_column = out_col_ff;
   assign rsp_ch.out_row    = out_row_ff;

   `ALNF_ASSERT_NEXT(a_accept_loads, req_ch.valid && req_ch.ready, state_ff == alnf_pkg::ST_LOAD, "accepted word did not start a line store update")
   `ALNF_ASSERT_NEXT(a_border_skips, state_ff == alnf_pkg::ST_LOAD && !emit_ff, state_ff == alnf_pkg::ST_IDLE && !(rsp_valid_ff && !$past(rsp_valid_ff)), "border pixel produced work")
   `ALNF_ASSERT_IMPL(a_div_nonzero, state_ff == alnf_pkg::ST_DIV, den_ff != '0, "division by zero variance")

endmodule

// File: rtl/core/alnf_line_mem.sv
// Line store RAM: one word per column holding the previous rows of that column.
// One write and one read port, read data registered. No package use.
module alnf_line_mem #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: dv/tb.sv
// Testbench for adaptive_local_noise_filter: raster RGB frames in, 7x7 filtered centres out.
// A scoreboard class predicts every centre result and compares the results in order.
// Depends on alnf_pkg, alnf_req_if, alnf_rsp_if, alnf_csr_if and the filter RTL.
module tb;

   localparam int WIN       = 7;
   localparam int HALF_WIN  = (WIN - 1) / 2;
   localparam int AREA      = WIN * WIN;
   localparam int MAX_COLS  = 1024;
   localparam int DRAIN_CYC = 80;
   localparam int STALL_LIM = 5000;
   localparam int NUM_ITEMS = 1200;

   typedef enum int {FILL_RANDOM, FILL_FLAT, FILL_SMOOTH, FILL_EXTREME, FILL_CHECKER}
      fill_kind_type;

   typedef struct {
      logic [alnf_pkg::CHAN_W-1:0]   red;
      logic [alnf_pkg::CHAN_W-1:0]   green;
      logic [alnf_pkg::CHAN_W-1:0]   blue;
      logic [alnf_pkg::COLUMN_W-1:0] column;
      logic [alnf_pkg::ROW_W-1:0]    row;
   } centre_type;

   class centre_scoreboard;
      logic [alnf_pkg::LWIDTH_W-1:0] line_width;
      logic [alnf_pkg::NOISE_W-1:0]  noise_var;
      logic [alnf_pkg::PIXEL_W-1:0]  prev_rows [WIN-1][MAX_COLS];
      logic [alnf_pkg::PIXEL_W-1:0]  win_px [AREA];
      int unsigned         col_cnt;
      int unsigned         row_cnt;
      centre_type          want_q [$];
      int                  errors;
      int                  matched;

      function new();
         line_width = alnf_pkg::LINE_WIDTH_RST;
         noise_var  = alnf_pkg::NOISE_RST;
         col_cnt    = 0;
         row_cnt    = 0;
         errors     = 0;
         matched    = 0;
         foreach (prev_rows[k, c]) prev_rows[k][c] = '0;
         foreach (win_px[i]) win_px[i] = '0;
      endfunction

      function void write_reg(logic [alnf_pkg::CSR_IDX_W-1:0] idx,
                              logic [alnf_pkg::CSR_DAT_W-1:0] data);
         if (idx == alnf_pkg::CSR_LINE_WIDTH) line_width = data[alnf_pkg::LWIDTH_W-1:0];
         else if (idx == alnf_pkg::CSR_NOISE_VARIANCE) noise_var = data;
      endfunction

      function longint div_half_even(longint num, longint den);
         longint quo, rem;
         quo = num / den;
         rem = num % den;
         if (2 * rem > den || (2 * rem == den && quo[0])) quo++;
         return quo;
      endfunction

      function logic [alnf_pkg::CHAN_W-1:0] filter_chan(int sh);
         longint s, q, d, thr, num, v, g, p;
         s = 0;
         q = 0;
         g = (win_px[HALF_WIN * WIN + HALF_WIN] >> sh) & 8'hFF;
         for (int i = 0; i < AREA; i++) begin
            p = (win_px[i] >> sh) & 8'hFF;
            s += p;
            q += p * p;
         end
         d   = AREA * q - s * s;
         thr = longint'(noise_var) * AREA * (AREA - 1);
         if (d == 0 || thr > d) begin
            v = div_half_even(s, AREA);
         end else begin
            num = g * d - longint'(noise_var) * (AREA - 1) * (AREA * g - s);
            v = (num <= 0) ? 0 : div_half_even(num, d);
         end
         return (v > 255) ? 8'hFF : v[alnf_pkg::CHAN_W-1:0];
      endfunction

      function void note_pixel(logic [alnf_pkg::CHAN_W-1:0] r, logic [alnf_pkg::CHAN_W-1:0] g,
                               logic [alnf_pkg::CHAN_W-1:0] b, logic sof);
         int unsigned wid, c;
         logic [alnf_pkg::PIXEL_W-1:0] px;
         centre_type res;
         if (sof) begin
            col_cnt = 0;
            row_cnt = 0;
         end
         wid = line_width;
         if (wid < 1) wid = 1;
         if (wid > MAX_COLS) wid = MAX_COLS;
         px = {b, g, r};
         c  = (col_cnt >= MAX_COLS) ? MAX_COLS - 1 : col_cnt;
         for (int k = 0; k < WIN; k++) begin
            for (int j = 0; j < WIN - 1; j++) win_px[k*WIN + j] = win_px[k*WIN + j + 1];
            win_px[k*WIN + WIN - 1] = (k < WIN - 1) ? prev_rows[k][c] : px;
         end
         for (int k = 0; k < WIN - 2; k++) prev_rows[k][c] = prev_rows[k+1][c];
         prev_rows[WIN-2][c] = px;
         if (row_cnt >= WIN - 1 && c >= WIN - 1) begin
            res.red    = filter_chan(0);
            res.green  = filter_chan(8);
            res.blue   = filter_chan(16);
            res.column = alnf_pkg::COLUMN_W'(c - HALF_WIN);
            res.row    = alnf_pkg::ROW_W'(row_cnt - HALF_WIN);
            want_q.push_back(res);
         end
         if (c + 1 >= wid) begin
            col_cnt = 0;
            if (row_cnt < alnf_pkg::ROW_MAX) row_cnt++;
         end else begin
            col_cnt = c + 1;
         end
      endfunction

      function void check_result(centre_type got);
         centre_type want;
         if (want_q.size() == 0) begin
            $display("%0t: unexpected result col %0d row %0d", $time, got.column, got.row);
            errors++;
            return;
         end
         want = want_q.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
             got.column !== want.column || got.row !== want.row) begin
            $display("%0t: mismatch exp rgb %0d/%0d/%0d at %0d,%0d act %0d/%0d/%0d at %0d,%0d",
                     $time, want.red, want.green, want.blue, want.column, want.row,
                     got.red, got.green, got.blue, got.column, got.row);
            errors++;
         end else begin
            matched++;
         end
      endfunction

      function int pending();
         return want_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   src_idle;
   int   snk_idle;
   int   items_sent;
   int   stall_cnt = 0;

   alnf_req_if req_ch ();
   alnf_rsp_if rsp_ch ();
   alnf_csr_if csr_ch ();

   centre_scoreboard sb = new();

   adaptive_local_noise_filter DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random back-pressure, check on every accepted word
   always @(posedge clock) begin
      centre_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.red    = rsp_ch.out_red;
         got.green  = rsp_ch.out_green;
         got.blue   = rsp_ch.out_blue;
         got.column = rsp_ch.out_column;
         got.row    = rsp_ch.out_row;
         sb.check_result(got);
      end
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
   end

   // watchdog on cycles with no traffic on any channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIM) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIM);
         $display("tb: errors");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   task automatic csr_write(logic [alnf_pkg::CSR_IDX_W-1:0] idx,
                            logic [alnf_pkg::CSR_DAT_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, data);
      csr_ch.valid <= 1'b0;
   endtask

   // valid stays high between back-to-back words; it drops only for a gap
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic sof);
      while ($urandom_range(99) < src_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.pixel_red      <= r;
      req_ch.pixel_green    <= g;
      req_ch.pixel_blue     <= b;
      req_ch.start_of_frame <= sof;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_pixel(r, g, b, sof);
      items_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_chan(fill_kind_type kind, int base, int spread,
                                            int col, int row);
      int v;
      case (kind)
         FILL_FLAT:    v = base;
         FILL_SMOOTH:  v = base + $urandom_range(2 * spread) - spread;
         FILL_EXTREME: v = $urandom_range(1) ? 255 : 0;
         FILL_CHECKER: v = ((col + row) % 2) ? 255 : 0;
         default:      v = $urandom_range(255);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   // one frame, possibly cut short after a given number of pixels
   task automatic send_frame(int cols, int rows, fill_kind_type kind, int cut);
      int base [3];
      int spread;
      int n;
      logic [7:0] ch [3];
      foreach (base[i]) base[i] = $urandom_range(255);
      spread = $urandom_range(1, 40);
      n = 0;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            if (cut >= 0 && n >= cut) return;
            foreach (ch[i]) ch[i] = pick_chan(kind, base[i], spread, c, r);
            send_pixel(ch[0], ch[1], ch[2], (r == 0 && c == 0));
            n++;
         end
      end
   endtask

   task automatic set_config(int unsigned lw, int unsigned nv);
      drain();
      csr_write(alnf_pkg::CSR_LINE_WIDTH, alnf_pkg::CSR_DAT_W'(lw));
      csr_write(alnf_pkg::CSR_NOISE_VARIANCE, alnf_pkg::CSR_DAT_W'(nv));
   endtask

   initial begin
      int unsigned lw, nv, eff;
      fill_kind_type kind;
      req_ch.valid          = 1'b0;
      req_ch.pixel_red      = '0;
      req_ch.pixel_green    = '0;
      req_ch.pixel_blue     = '0;
      req_ch.start_of_frame = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = alnf_pkg::CSR_LINE_WIDTH;
      csr_ch.data           = '0;
      src_idle   = 0;
      snk_idle   = 0;
      items_sent = 0;
      reset      = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: flat images (zero variance), full swing, both decision paths
      set_config(WIN, 0);
      send_frame(WIN, WIN, FILL_FLAT, -1);
      send_frame(WIN, WIN + 1, FILL_CHECKER, -1);
      send_frame(WIN + 1, WIN, FILL_EXTREME, -1);
      set_config(WIN, 16'hFFFF);
      send_frame(WIN, WIN, FILL_RANDOM, -1);
      send_frame(WIN, WIN, FILL_CHECKER, -1);
      // widths too small for any centre, and zero width
      set_config(0, 1);
      send_frame(1, 12, FILL_RANDOM, -1);
      set_config(3, 1);
      send_frame(3, 8, FILL_RANDOM, -1);

      items_sent = 0;
      lw = WIN;
      for (int ph = 0; ph < 3; ph++) begin
         src_idle = (ph == 0) ? 21 : (ph == 1) ? 72 : 0;
         snk_idle = (ph == 0) ? 72 : (ph == 1) ? 21 : 0;
         while (items_sent < (ph + 1) * NUM_ITEMS / 3) begin
            if ($urandom_range(2) == 0) begin
               lw = ($urandom_range(5) == 0) ? $urandom_range(WIN, 40)
                                             : $urandom_range(WIN, 14);
               case ($urandom_range(4))
                  0:       nv = 0;
                  1:       nv = 16'hFFFF;
                  2:       nv = $urandom_range(16'hFFFF);
                  default: nv = $urandom_range(2000);
               endcase
               set_config(lw, nv);
            end
            eff = lw;
            kind = fill_kind_type'($urandom_range(4));
            if ($urandom_range(9) == 0)
               send_frame(eff, $urandom_range(1, WIN - 1), kind, -1);
            else if ($urandom_range(7) == 0)
               send_frame(eff, WIN + 2, kind, $urandom_range(1, eff * (WIN + 2)));
            else
               send_frame(eff, $urandom_range(WIN, WIN + 3), kind, -1);
         end
      end

      drain();
      $display("tb: %0d results matched over line widths 0 to 40 and noise variance 0..65535",
               sb.matched);
      $display("tb: random frames flat, smooth, checker, extreme and cut short");
      if (sb.pending() != 0) begin
         $display("%0t: %0d results never arrived", $time, sb.pending());
         sb.errors += sb.pending();
      end
      if (sb.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
